// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/psf_pkg.sv =====
// ---------------------------------------------------------------------------
// psf_pkg
// widths and sizes shared by the prime sieve filter chain
// ---------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int MAX_PRIMES  = 16;

  // table index and fill count
  localparam int IDX_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int CNT_W = $clog2(MAX_PRIMES + 1);

  // one quotient bit per divider step
  localparam int DIV_STEPS = VALUE_WIDTH;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [STEP_W-1:0]      step_t;

endpackage

`default_nettype wire

// ===== sv/prime_sieve_filter_chain_top.sv =====
// ---------------------------------------------------------------------------
// prime sieve filter chain
// trial-division sieve over a table of the primes found so far
// ---------------------------------------------------------------------------
// usage
//   in_ channel carries candidates, expected ascending from 2; out_ channel
//   carries a prime with its table_full flag; a composite gives no item
//   the first candidate after reset is always stored and emitted
//   each candidate is tested against the stored primes in table order until
//   one divides it; one test is a table read, a data load, a restoring
//   remainder of 16 steps and a check; a prime is tested against every
//   stored prime, and a composite stops at the first entry that divides it
//   one item is in flight at a time; the divider loop sets the rate
//   a finished item sits in the output register, and the next candidate is
//   accepted while it waits; if the receiver still stalls when the next
//   prime is done, the block holds in the emit state until the slot frees
//   when the table is full a prime is emitted with table_full set and not
//   stored
//   reset clears the prime count and the output valid; table contents are
//   not cleared, only entries below the count are ever read
// ---------------------------------------------------------------------------
`default_nettype none

module prime_sieve_filter_chain_top (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [psf_pkg::VALUE_WIDTH-1:0] in_candidate,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [psf_pkg::VALUE_WIDTH-1:0] out_found_prime,
  output logic                           out_table_full
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_DIV,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t          state_r;
  psf_pkg::value_t cand_r;     // candidate under test
  psf_pkg::cnt_t   count_r;    // stored primes
  psf_pkg::idx_t   idx_r;      // table entry under test
  psf_pkg::value_t div_r;      // divisor from the table
  psf_pkg::value_t dvd_r;      // dividend bits still to shift in
  psf_pkg::value_t rem_r;      // partial remainder
  psf_pkg::step_t  step_r;     // divider steps left

  logic            out_valid_r;
  psf_pkg::value_t out_prime_r;
  logic            out_full_r;

  // prime table, synchronous read
  psf_pkg::value_t mem [psf_pkg::MAX_PRIMES];
  psf_pkg::value_t rd_data_r;

  // divider step: shift in one dividend bit, subtract if it fits
  logic [psf_pkg::VALUE_WIDTH:0] trial;
  logic [psf_pkg::VALUE_WIDTH:0] trial_sub;
  psf_pkg::value_t               rem_nxt;

  // check and emit control
  psf_pkg::cnt_t next_idx;
  logic          last_entry;
  logic          hit;
  logic          slot_free;
  logic          emit_go;
  logic          table_full;
  logic          mem_we;
  logic          in_fire;

  always_comb begin
    trial     = {rem_r, dvd_r[psf_pkg::VALUE_WIDTH-1]};
    trial_sub = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = trial_sub[psf_pkg::VALUE_WIDTH-1:0];
    end else begin
      rem_nxt = trial[psf_pkg::VALUE_WIDTH-1:0];
    end
  end

  assign next_idx   = psf_pkg::CNT_W'(idx_r) + psf_pkg::CNT_W'(1);
  assign last_entry = (next_idx == count_r);
  // a zero entry divides nothing
  assign hit        = (div_r != '0) && (rem_r == '0);
  assign slot_free  = !out_valid_r || out_ready;
  assign emit_go    = (state_r == S_EMIT) && slot_free;
  assign table_full = (count_r == psf_pkg::CNT_W'(psf_pkg::MAX_PRIMES));
  assign mem_we     = emit_go && !table_full;

  assign in_ready        = (state_r == S_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_found_prime = out_prime_r;
  assign out_table_full  = out_full_r;

  // table: written at the count in the emit state, read at the entry under test every cycle; one item at a time
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[psf_pkg::IDX_W-1:0]] <= cand_r;
    end
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new item takes the slot, else a taken item frees it
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cand_r <= in_candidate;
            idx_r  <= '0;
            if (count_r == '0) begin
              state_r <= S_EMIT;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          div_r   <= rd_data_r;
          dvd_r   <= cand_r;
          rem_r   <= '0;
          step_r  <= psf_pkg::STEP_W'(psf_pkg::DIV_STEPS);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          dvd_r  <= {dvd_r[psf_pkg::VALUE_WIDTH-2:0], 1'b0};
          step_r <= step_r - psf_pkg::STEP_W'(1);
          if (step_r == psf_pkg::STEP_W'(1)) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (hit) begin
            state_r <= S_IDLE;
          end else if (last_entry) begin
            state_r <= S_EMIT;
          end else begin
            idx_r   <= next_idx[psf_pkg::IDX_W-1:0];
            state_r <= S_READ;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_prime_r <= cand_r;
            out_full_r  <= table_full;
            if (!table_full) begin
              count_r <= count_r + psf_pkg::CNT_W'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound,
    count_r <= psf_pkg::CNT_W'(psf_pkg::MAX_PRIMES),
    "prime count past table size")
  `ASSERT_IMPLIES(a_div_steps, state_r == S_DIV,
    step_r != '0 && step_r <= psf_pkg::STEP_W'(psf_pkg::DIV_STEPS),
    "divider step count out of range")
  `ASSERT_NEXT(a_store_grows, mem_we,
    count_r == $past(count_r) + psf_pkg::CNT_W'(1),
    "table write without count advance")
  `ASSERT_IMPLIES(a_rise_from_emit, $rose(out_valid_r), $past(state_r) == S_EMIT,
    "result raised outside emit")

endmodule

`default_nettype wire
